[src/sepconv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sepconv_pkg
// Shared types and fixed widths of the separable 5x5 mirror convolution.
// ----------------------------------------------------------------------------
package sepconv_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int WEIGHT_W  = 18;
  localparam int RING_ROWS = 5;
  localparam int RING_W    = 3;
  localparam int TAP_W     = 3;
  localparam int HPROD_W   = SAMPLE_W + WEIGHT_W;
  localparam int ROWSUM_W  = HPROD_W + 3;
  localparam int VPROD_W   = ROWSUM_W + WEIGHT_W;
  localparam int ACC_W     = VPROD_W + 3;
  localparam int FRAC_W    = 32;
  localparam int RES_W     = ACC_W - FRAC_W;
  localparam int CFG_W     = 32;
  localparam int ADDR_W    = 5;
  localparam int REGIDX_W  = 3;
  localparam int WREG_W    = 11;
  localparam int HREG_W    = 13;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  localparam logic [REGIDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [REGIDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [REGIDX_W-1:0] REG_H_CENTER     = 3'd2;
  localparam logic [REGIDX_W-1:0] REG_H_NEAR       = 3'd3;
  localparam logic [REGIDX_W-1:0] REG_H_FAR        = 3'd4;
  localparam logic [REGIDX_W-1:0] REG_V_CENTER     = 3'd5;
  localparam logic [REGIDX_W-1:0] REG_V_NEAR       = 3'd6;
  localparam logic [REGIDX_W-1:0] REG_V_FAR        = 3'd7;

  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       row_end;
    logic                       frame_end;
    logic                       run_last;
  } out_item_t;

  typedef struct packed {
    logic                       is_sample;
    logic signed [SAMPLE_W-1:0] sample;
  } job_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] h_center;
    logic signed [WEIGHT_W-1:0] h_near;
    logic signed [WEIGHT_W-1:0] h_far;
    logic signed [WEIGHT_W-1:0] v_center;
    logic signed [WEIGHT_W-1:0] v_near;
    logic signed [WEIGHT_W-1:0] v_far;
  } weights_t;

endpackage

[src/sepconv_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sepconv_front
// Accepts input items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module sepconv_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  sepconv_pkg::in_item_t in_item,
  output logic                  full,
  input  logic                  job_pop,
  output logic                  job_valid,
  output sepconv_pkg::job_t     job
);

  sepconv_pkg::job_t q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;
  sepconv_pkg::job_t push_job;

  assign full      = (count_r == 2'd2);
  assign job_valid = (count_r != 2'd0);
  assign job       = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = job_pop && job_valid;

  always_comb begin
    push_job.is_sample = (in_item.op == sepconv_pkg::OP_SAMPLE);
    push_job.sample    = in_item.sample;
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[src/sepconv_outq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sepconv_outq
// Four-entry queue of finished result items toward the output port.
// ----------------------------------------------------------------------------
module sepconv_outq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_push,
  input  sepconv_pkg::out_item_t res_item,
  output logic                   res_full,
  input  logic                   pop,
  output logic                   empty,
  output sepconv_pkg::out_item_t out_item
);

  sepconv_pkg::out_item_t q_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign res_full = (count_r == 3'd4);
  assign empty    = (count_r == 3'd0);
  assign out_item = q_r[rd_ptr_r];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + 2'(do_push);
    rd_ptr_nxt = rd_ptr_r + 2'(do_pop);
    count_nxt  = count_r + 3'(do_push) - 3'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= res_item;
    end
  end

endmodule

[src/sepconv_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sepconv_back
// Line store, frame positions and the shared multiply-accumulate sequencer.
// ----------------------------------------------------------------------------
module sepconv_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]       eff_h,
  input  sepconv_pkg::weights_t                 weights,
  input  logic                                  job_valid,
  input  sepconv_pkg::job_t                     job,
  output logic                                  job_pop,
  output logic                                  res_push,
  output sepconv_pkg::out_item_t                res_item,
  input  logic                                  res_full
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int PW   = CW + 2;
  localparam int QW   = RW + 2;
  localparam int MA_W = CW + sepconv_pkg::RING_W;
  localparam int DEPTH = sepconv_pkg::RING_ROWS << CW;
  localparam int SW   = sepconv_pkg::SAMPLE_W;
  localparam int WW   = sepconv_pkg::WEIGHT_W;
  localparam int AW   = sepconv_pkg::ACC_W;
  localparam int RSW  = sepconv_pkg::RES_W;
  localparam int TW   = sepconv_pkg::TAP_W;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_TAKE  = 9'b000000010,
    ST_CHECK = 9'b000000100,
    ST_ADDR  = 9'b000001000,
    ST_DATA  = 9'b000010000,
    ST_ACC   = 9'b000100000,
    ST_VMUL  = 9'b001000000,
    ST_VACC  = 9'b010000000,
    ST_ROUND = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [SW-1:0] line_mem [DEPTH];

  logic [CW-1:0]                 in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [RW-1:0]                 in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [sepconv_pkg::RING_W-1:0] in_ring_r, in_ring_nxt, out_ring_r, out_ring_nxt;
  logic                          fr_r, fr_nxt;
  logic [1:0]                    n_r, n_nxt;
  logic [TW-1:0]                 dx_r, dx_nxt, dy_r, dy_nxt;

  logic signed [SW-1:0]                    rd_data_r;
  logic signed [sepconv_pkg::HPROD_W-1:0]  hprod_r;
  logic signed [sepconv_pkg::ROWSUM_W-1:0] rowsum_r;
  logic signed [sepconv_pkg::VPROD_W-1:0]  vprod_r;
  logic signed [AW-1:0]                    acc_r;

  logic [PW-1:0] col_last;
  logic [QW-1:0] row_last;
  logic          mem_we;
  logic [MA_W-1:0] wr_addr, rd_addr;

  logic signed [PW:0] cv, mc, col_last_s;
  logic signed [QW:0] rv, mr, row_last_s, rdiff;
  logic [3:0]         rsum;
  logic [sepconv_pkg::RING_W-1:0] rd_ring;

  logic signed [WW-1:0] wx, wy;
  logic signed [AW-1:0] rnd;
  logic signed [RSW-1:0] shifted;
  logic signed [SW-1:0]  sat;

  logic rend, fend, last, ready_now;
  logic [CW-1:0] nc;
  logic [RW-1:0] nr;
  logic [sepconv_pkg::RING_W-1:0] nring;

  function automatic logic is_ready(
    input logic [CW-1:0] oc, input logic [RW-1:0] orow,
    input logic [CW-1:0] ic, input logic [RW-1:0] ir, input logic fr,
    input logic [PW-1:0] cl, input logic [QW-1:0] rl);
    logic [PW-1:0] need_c;
    logic [QW-1:0] need_r;
    need_c = (PW'(oc) + PW'(2) > cl) ? cl : PW'(oc) + PW'(2);
    need_r = (QW'(orow) + QW'(2) > rl) ? rl : QW'(orow) + QW'(2);
    return fr || (QW'(ir) > need_r) || ((QW'(ir) == need_r) && (PW'(ic) > need_c));
  endfunction

  assign col_last = PW'(eff_w) - PW'(1);
  assign row_last = QW'(eff_h) - QW'(1);

  // Mirrored window addressing for the current tap.
  always_comb begin
    col_last_s = $signed((PW+1)'(col_last));
    cv = $signed((PW+1)'(out_col_r)) + $signed((PW+1)'(dx_r)) - $signed((PW+1)'(2));
    if (cv < 0) begin
      mc = ~cv;
    end else if (cv > col_last_s) begin
      mc = (col_last_s <<< 1) + $signed((PW+1)'(1)) - cv;
    end else begin
      mc = cv;
    end
    row_last_s = $signed((QW+1)'(row_last));
    rv = $signed((QW+1)'(out_row_r)) + $signed((QW+1)'(dy_r)) - $signed((QW+1)'(2));
    if (rv < 0) begin
      mr = ~rv;
    end else if (rv > row_last_s) begin
      mr = (row_last_s <<< 1) + $signed((QW+1)'(1)) - rv;
    end else begin
      mr = rv;
    end
    rdiff = mr - $signed((QW+1)'(out_row_r));
    rsum  = 4'(out_ring_r) + rdiff[3:0] + 4'd5;
    if (rsum >= 4'd10) begin
      rd_ring = sepconv_pkg::RING_W'(rsum - 4'd10);
    end else if (rsum >= 4'd5) begin
      rd_ring = sepconv_pkg::RING_W'(rsum - 4'd5);
    end else begin
      rd_ring = sepconv_pkg::RING_W'(rsum);
    end
    rd_addr = {rd_ring, mc[CW-1:0]};
    wr_addr = {in_ring_r, in_col_r};
  end

  // Taps are symmetric, picked by distance from the center.
  always_comb begin
    unique case (dx_r)
      3'd0, 3'd4: wx = weights.h_far;
      3'd1, 3'd3: wx = weights.h_near;
      default:    wx = weights.h_center;
    endcase
    unique case (dy_r)
      3'd0, 3'd4: wy = weights.v_far;
      3'd1, 3'd3: wy = weights.v_near;
      default:    wy = weights.v_center;
    endcase
  end

  // Round half up, then saturate.
  always_comb begin
    rnd     = acc_r + (AW'(1) <<< (sepconv_pkg::FRAC_W - 1));
    shifted = RSW'(rnd >>> sepconv_pkg::FRAC_W);
    if (shifted < $signed(RSW'(-(1 <<< (SW-1))))) begin
      sat = $signed(SW'(1 <<< (SW-1)));
    end else if (shifted > $signed(RSW'((1 <<< (SW-1)) - 1))) begin
      sat = $signed(SW'((1 <<< (SW-1)) - 1));
    end else begin
      sat = SW'(shifted);
    end
  end

  assign mem_we    = (state_r == ST_TAKE) && job.is_sample && !fr_r;
  assign job_pop   = (state_r == ST_TAKE);
  assign ready_now = is_ready(out_col_r, out_row_r, in_col_r, in_row_r, fr_r,
                              col_last, row_last);

  always_comb begin
    state_nxt    = state_r;
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    in_ring_nxt  = in_ring_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_ring_nxt = out_ring_r;
    fr_nxt       = fr_r;
    n_nxt        = n_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    res_push     = 1'b0;
    rend  = (PW'(out_col_r) == col_last);
    fend  = rend && (QW'(out_row_r) == row_last);
    nc    = out_col_r;
    nr    = out_row_r;
    nring = out_ring_r;
    last  = 1'b1;
    res_item.filtered  = sat;
    res_item.row_end   = rend;
    res_item.frame_end = fend;
    res_item.run_last  = 1'b1;

    if (!fend) begin
      if (rend) begin
        nc = '0;
        nr = out_row_r + RW'(1);
        nring = (out_ring_r == sepconv_pkg::RING_W'(sepconv_pkg::RING_ROWS - 1)) ?
                '0 : out_ring_r + sepconv_pkg::RING_W'(1);
      end else begin
        nc = out_col_r + CW'(1);
      end
      last = (n_r == 2'd2) ||
             !is_ready(nc, nr, in_col_r, in_row_r, fr_r, col_last, row_last);
    end
    res_item.run_last = last;

    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          state_nxt = ST_TAKE;
        end
      end
      ST_TAKE: begin
        if (job.is_sample && !fr_r) begin
          if (PW'(in_col_r) == col_last) begin
            in_col_nxt = '0;
            if (QW'(in_row_r) == row_last) begin
              fr_nxt = 1'b1;
            end else begin
              in_row_nxt  = in_row_r + RW'(1);
              in_ring_nxt = (in_ring_r == sepconv_pkg::RING_W'(sepconv_pkg::RING_ROWS - 1)) ?
                            '0 : in_ring_r + sepconv_pkg::RING_W'(1);
            end
          end else begin
            in_col_nxt = in_col_r + CW'(1);
          end
        end
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        n_nxt  = 2'd0;
        dx_nxt = '0;
        dy_nxt = '0;
        state_nxt = ready_now ? ST_ADDR : ST_IDLE;
      end
      ST_ADDR:  state_nxt = ST_DATA;
      ST_DATA:  state_nxt = ST_ACC;
      ST_ACC: begin
        if (dx_r == TW'(4)) begin
          dx_nxt    = '0;
          state_nxt = ST_VMUL;
        end else begin
          dx_nxt    = dx_r + TW'(1);
          state_nxt = ST_ADDR;
        end
      end
      ST_VMUL:  state_nxt = ST_VACC;
      ST_VACC: begin
        if (dy_r == TW'(4)) begin
          dy_nxt    = '0;
          state_nxt = ST_ROUND;
        end else begin
          dy_nxt    = dy_r + TW'(1);
          state_nxt = ST_ADDR;
        end
      end
      ST_ROUND: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (fend) begin
            in_col_nxt   = '0;
            in_row_nxt   = '0;
            in_ring_nxt  = '0;
            out_col_nxt  = '0;
            out_row_nxt  = '0;
            out_ring_nxt = '0;
            fr_nxt       = 1'b0;
          end else begin
            out_col_nxt  = nc;
            out_row_nxt  = nr;
            out_ring_nxt = nring;
          end
          n_nxt     = n_r + 2'd1;
          state_nxt = last ? ST_IDLE : ST_ADDR;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (restart) begin
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      in_ring_nxt  = '0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      out_ring_nxt = '0;
      fr_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_ring_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_ring_r <= '0;
      fr_r       <= 1'b0;
      n_r        <= 2'd0;
      dx_r       <= '0;
      dy_r       <= '0;
    end else begin
      state_r    <= state_nxt;
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      in_ring_r  <= in_ring_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_ring_r <= out_ring_nxt;
      fr_r       <= fr_nxt;
      n_r        <= n_nxt;
      dx_r       <= dx_nxt;
      dy_r       <= dy_nxt;
    end
  end

  // Line store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[wr_addr] <= job.sample;
    end
    rd_data_r <= $signed(line_mem[rd_addr]);
  end

  // Multiply-accumulate datapath: horizontal taps per row, then the row weight.
  // The sum is held while a finished result waits for room in the queue.
  always_ff @(posedge clk) begin
    if (state_r == ST_DATA) begin
      hprod_r <= rd_data_r * wx;
    end
    if ((state_r == ST_CHECK) || (state_r == ST_ROUND) || (state_r == ST_VACC)) begin
      rowsum_r <= '0;
    end else if (state_r == ST_ACC) begin
      rowsum_r <= rowsum_r + hprod_r;
    end
    if (state_r == ST_VMUL) begin
      vprod_r <= rowsum_r * wy;
    end
    if ((state_r == ST_CHECK) || ((state_r == ST_ROUND) && res_push)) begin
      acc_r <= '0;
    end else if (state_r == ST_VACC) begin
      acc_r <= acc_r + vprod_r;
    end
  end

endmodule

[src/separable_5x5_mirror_convolution_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_5x5_mirror_convolution_top
// Streaming 5x5 separable convolution with mirrored borders and a register port.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                   Moves
//  --------  --------------------------------------  -------------------------
//  input     push, full, in_item                     one sample or drain item
//  result    pop, empty, out_item                    one filtered result item
//  config    psel, penable, pwrite, paddr, pwdata,   register writes and reads
//            prdata, pready
//
// Each input item passes IDLE, TAKE and CHECK to be taken in and checked, plus
// ADDR, DATA and ACC per tap, VMUL and VACC per row and ROUND per result it
// releases (at most three), since all 25 window taps go one after another
// through a single line store read port and one shared multiply-accumulate unit.
// A front queue of two items keeps accepting while the back end works, and a
// four-entry result queue holds finished items while the consumer stalls.
// Reset is synchronous and active low; the line store itself is not cleared,
// since every window reads only samples of the current frame.
// Writing the width or height register restarts the frame.
//
module separable_5x5_mirror_convolution_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  input  sepconv_pkg::in_item_t                  in_item,
  output logic                                   full,
  input  logic                                   pop,
  output logic                                   empty,
  output sepconv_pkg::out_item_t                 out_item,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [sepconv_pkg::ADDR_W-1:0]         paddr,
  input  logic [sepconv_pkg::CFG_W-1:0]          pwdata,
  output logic [sepconv_pkg::CFG_W-1:0]          prdata,
  output logic                                   pready
);

  localparam int WV  = $clog2(MAX_WIDTH + 1);
  localparam int HV  = $clog2(MAX_HEIGHT + 1);
  localparam int WCW = (WV > sepconv_pkg::WREG_W) ? WV : sepconv_pkg::WREG_W;
  localparam int HCW = (HV > sepconv_pkg::HREG_W) ? HV : sepconv_pkg::HREG_W;
  localparam int WW  = sepconv_pkg::WEIGHT_W;

  logic [sepconv_pkg::WREG_W-1:0] width_r;
  logic [sepconv_pkg::HREG_W-1:0] height_r;
  sepconv_pkg::weights_t          weights_r;

  logic                                cfg_wr;
  logic [sepconv_pkg::REGIDX_W-1:0]    reg_idx;
  logic                                restart;
  logic [WCW-1:0]                      w_ext;
  logic [HCW-1:0]                      h_ext;
  logic [WV-1:0]                       eff_w;
  logic [HV-1:0]                       eff_h;

  logic                   job_valid, job_pop;
  sepconv_pkg::job_t      job;
  logic                   res_push, res_full;
  sepconv_pkg::out_item_t res_item;

  assign pready  = 1'b1;
  assign reg_idx = paddr[sepconv_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign restart = cfg_wr && ((reg_idx == sepconv_pkg::REG_IMAGE_WIDTH) ||
                              (reg_idx == sepconv_pkg::REG_IMAGE_HEIGHT));

  // Frame size is clamped to the range the line store supports.
  always_comb begin
    w_ext = WCW'(width_r);
    h_ext = HCW'(height_r);
    if (w_ext < WCW'(3)) begin
      eff_w = WV'(3);
    end else if (w_ext > WCW'(MAX_WIDTH)) begin
      eff_w = WV'(MAX_WIDTH);
    end else begin
      eff_w = WV'(w_ext);
    end
    if (h_ext < HCW'(3)) begin
      eff_h = HV'(3);
    end else if (h_ext > HCW'(MAX_HEIGHT)) begin
      eff_h = HV'(MAX_HEIGHT);
    end else begin
      eff_h = HV'(h_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r            <= sepconv_pkg::WREG_W'(1024);
      height_r           <= sepconv_pkg::HREG_W'(4096);
      weights_r.h_center <= WW'(65536);
      weights_r.h_near   <= '0;
      weights_r.h_far    <= '0;
      weights_r.v_center <= WW'(65536);
      weights_r.v_near   <= '0;
      weights_r.v_far    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sepconv_pkg::REG_IMAGE_WIDTH:  width_r <= pwdata[sepconv_pkg::WREG_W-1:0];
        sepconv_pkg::REG_IMAGE_HEIGHT: height_r <= pwdata[sepconv_pkg::HREG_W-1:0];
        sepconv_pkg::REG_H_CENTER:     weights_r.h_center <= pwdata[WW-1:0];
        sepconv_pkg::REG_H_NEAR:       weights_r.h_near <= pwdata[WW-1:0];
        sepconv_pkg::REG_H_FAR:        weights_r.h_far <= pwdata[WW-1:0];
        sepconv_pkg::REG_V_CENTER:     weights_r.v_center <= pwdata[WW-1:0];
        sepconv_pkg::REG_V_NEAR:       weights_r.v_near <= pwdata[WW-1:0];
        sepconv_pkg::REG_V_FAR:        weights_r.v_far <= pwdata[WW-1:0];
        default: ;
      endcase
    end
  end

  // Read data is the stored register, zero-extended to the bus.
  always_comb begin
    unique case (reg_idx)
      sepconv_pkg::REG_IMAGE_WIDTH:  prdata = sepconv_pkg::CFG_W'(width_r);
      sepconv_pkg::REG_IMAGE_HEIGHT: prdata = sepconv_pkg::CFG_W'(height_r);
      sepconv_pkg::REG_H_CENTER:     prdata = sepconv_pkg::CFG_W'(unsigned'(weights_r.h_center));
      sepconv_pkg::REG_H_NEAR:       prdata = sepconv_pkg::CFG_W'(unsigned'(weights_r.h_near));
      sepconv_pkg::REG_H_FAR:        prdata = sepconv_pkg::CFG_W'(unsigned'(weights_r.h_far));
      sepconv_pkg::REG_V_CENTER:     prdata = sepconv_pkg::CFG_W'(unsigned'(weights_r.v_center));
      sepconv_pkg::REG_V_NEAR:       prdata = sepconv_pkg::CFG_W'(unsigned'(weights_r.v_near));
      sepconv_pkg::REG_V_FAR:        prdata = sepconv_pkg::CFG_W'(unsigned'(weights_r.v_far));
      default:                       prdata = '0;
    endcase
  end

  sepconv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .job_pop   (job_pop),
    .job_valid (job_valid),
    .job       (job)
  );

  sepconv_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .weights   (weights_r),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .res_push  (res_push),
    .res_item  (res_item),
    .res_full  (res_full)
  );

  sepconv_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_item (res_item),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule
